/* hw/rtl/pci_pkg.sv */
`timescale 1ns / 1ps
// Shared widths and defaults for the perspective-correct interpolator.
// No dependencies; used by the channel interfaces, pci_recip and the top level.
package pci_pkg;
    localparam int FRAC_BITS_DEF = 16;  // default fraction bits of Q values
    localparam int WEIGHT_BITS   = 16;  // barycentric weights are Q1.16
    localparam int VAL_W         = 32;  // Q values and results
    localparam int BARY_W        = 17;  // barycentric weight code
    localparam int QMAG_W        = 33;  // reciprocal magnitude, capped at 2^32
    localparam int DMAG_W        = 50;  // magnitude of the weighted reciprocal sum
endpackage

/* hw/rtl/pci_if.sv */
`timescale 1ns / 1ps
// Valid/ready channel interfaces of the perspective-correct interpolator.
// Depends on pci_pkg for field widths.
interface pci_frag_if;
    import pci_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [VAL_W-1:0] clip_w_first;
    logic signed [VAL_W-1:0] clip_w_second;
    logic signed [VAL_W-1:0] clip_w_third;
    logic [BARY_W-1:0]       bary_first;
    logic [BARY_W-1:0]       bary_second;
    logic [BARY_W-1:0]       bary_third;
    logic signed [VAL_W-1:0] attr_first;
    logic signed [VAL_W-1:0] attr_second;
    logic signed [VAL_W-1:0] attr_third;
    modport source (output valid, clip_w_first, clip_w_second, clip_w_third,
                    bary_first, bary_second, bary_third,
                    attr_first, attr_second, attr_third, input ready);
    modport sink (input valid, clip_w_first, clip_w_second, clip_w_third,
                  bary_first, bary_second, bary_third,
                  attr_first, attr_second, attr_third, output ready);
endinterface

interface pci_result_if;
    import pci_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [VAL_W-1:0] interp_value;
    logic                    saturated;
    modport source (output valid, interp_value, saturated, input ready);
    modport sink (input valid, interp_value, saturated, output ready);
endinterface

interface pci_cfg_if;
    logic valid;
    logic ready;
    logic perspective_enable;
    modport source (output valid, perspective_enable, input ready);
    modport sink (input valid, perspective_enable, output ready);
endinterface

/* hw/rtl/pci_recip.sv */
`timescale 1ns / 1ps
// Pipelined reciprocal: round(2^K / d), one quotient bit per stage, capped at 2^32.
// Depends on pci_pkg. Each quotient step is registered, then an output register; all advance when en is high.
module pci_recip #(
    parameter int K  = 32,
    parameter int DW = 32
) (
    input  logic                       clk,
    input  logic                       en,
    input  logic [DW-1:0]              d,
    output logic [pci_pkg::QMAG_W-1:0] mag
);
    import pci_pkg::*;

    localparam int NB = K + 2;       // quotient bits of floor(2^(K+1) / d)
    localparam int QW = QMAG_W + 1;  // low quotient bits kept; higher ones only flag

    logic [DW-1:0]     rem_reg [NB];
    logic [DW-1:0]     div_reg [NB];
    logic [QW-1:0]     quo_reg [NB];
    logic              ovf_reg [NB];
    logic [QMAG_W-1:0] mag_reg;
    logic [QMAG_W-1:0] mag_next;
    logic [QW:0]       rnd;

    genvar j;
    for (j = 0; j < NB; j++)
    begin : g_step
        logic [DW-1:0] rem_prev;
        logic [DW-1:0] div_prev;
        logic [QW-1:0] quo_prev;
        logic          ovf_prev;
        logic [DW:0]   shifted;
        logic [DW:0]   diff;
        logic          ge;
        logic [DW-1:0] rem_next;
        logic [QW-1:0] quo_next;
        logic          ovf_next;

        if (j == 0)
        begin : g_first
            assign rem_prev = '0;
            assign div_prev = d;
            assign quo_prev = '0;
            assign ovf_prev = 1'b0;
        end
        else
        begin : g_rest
            assign rem_prev = rem_reg[j-1];
            assign div_prev = div_reg[j-1];
            assign quo_prev = quo_reg[j-1];
            assign ovf_prev = ovf_reg[j-1];
        end

        // the numerator is a single one bit, brought in at the first step
        assign shifted  = {rem_prev, 1'(j == 0)};
        assign diff     = shifted - {1'b0, div_prev};
        assign ge       = ~diff[DW];
        assign rem_next = ge ? diff[DW-1:0] : shifted[DW-1:0];
        assign quo_next = {quo_prev[QW-2:0], ge};
        assign ovf_next = ovf_prev | quo_prev[QW-1];

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[j] <= rem_next;
                div_reg[j] <= div_prev;
                quo_reg[j] <= quo_next;
                ovf_reg[j] <= ovf_next;
            end
        end
    end

    // round half up: (floor(2N/d) + 1) / 2
    assign rnd = {1'b0, quo_reg[NB-1]} + (QW + 1)'(1);

    always_comb
    begin
        if (ovf_reg[NB-1] || rnd[QW:QW-1] != 2'b00)
            mag_next = QMAG_W'(1) << (QMAG_W - 1);
        else
            mag_next = rnd[QMAG_W:1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            mag_reg <= mag_next;
    end

    assign mag = mag_reg;
endmodule

/* hw/rtl/perspective_correct_interpolator_top.sv */
`timescale 1ns / 1ps
// Perspective-correct interpolator; its depth is set mostly by two bit-per-stage reciprocal
// steps in series: 1/w (three pci_recip in parallel), then 1/(weighted reciprocal sum).
// Throughput one fragment beat per cycle; a two-entry output buffer takes results
// while the sink stalls, and the whole pipe holds only when that buffer is full.
// Reset (rst_n low, async) clears valid bits and buffer; perspective_enable resets to 1.
// Depends on pci_pkg, pci_if and pci_recip.
module perspective_correct_interpolator_top #(
    parameter int FRAC_BITS = pci_pkg::FRAC_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    pci_cfg_if.sink      cfg,
    pci_frag_if.sink     frag,
    pci_result_if.source result
);
    import pci_pkg::*;

    localparam int KW   = 2 * FRAC_BITS;
    localparam int KD   = 2 * FRAC_BITS + WEIGHT_BITS;
    localparam int LW   = KW + 3;
    localparam int LD   = KD + 3;
    localparam int NSTG = LW + LD + 9;

    typedef struct packed {
        logic                        pe;
        logic [2:0]                  wneg;
        logic [2:0]                  wzero;
        logic [2:0][BARY_W-1:0]      bary;
        logic [2:0][VAL_W-1:0]       attr;
        logic [VAL_W-1:0]            plain_res;
        logic                        plain_sat;
    } side_w_t;

    typedef struct packed {
        logic             pe;
        logic [VAL_W-1:0] plain_res;
        logic             plain_sat;
        logic             dneg;
        logic             dzero;
        logic [VAL_W-1:0] pval;
        logic             flag;
    } side_d_t;

    function automatic logic signed [63:0] shr_rnd(input logic signed [63:0] x,
                                                   input int s);
        logic signed [63:0] t;
        t = x + (64'sd1 <<< (s - 1));
        return t >>> s;
    endfunction

    // returns {clamped, value}
    function automatic logic [VAL_W:0] sat32(input logic signed [63:0] x);
        if (x > 64'sd2147483647)
            return {1'b1, 32'h7fff_ffff};
        if (x < -64'sd2147483648)
            return {1'b1, 32'h8000_0000};
        return {1'b0, x[31:0]};
    endfunction

    function automatic logic [VAL_W:0] recip_fix(input logic [QMAG_W-1:0] mag,
                                                 input logic neg, input logic zero);
        if (zero)
            return {1'b1, 32'h7fff_ffff};
        if (!neg)
        begin
            if (mag > 33'h0_7fff_ffff)
                return {1'b1, 32'h7fff_ffff};
            return {1'b0, mag[31:0]};
        end
        if (mag > 33'h0_8000_0000)
            return {1'b1, 32'h8000_0000};
        return {1'b0, ~mag[31:0] + 32'd1};
    endfunction

    logic adv;
    logic in_acc;
    logic pe_reg;
    logic [NSTG-1:0] vld_reg;

    // input stage
    logic [2:0][VAL_W-1:0]  i_w_reg;
    logic [2:0][BARY_W-1:0] i_b_reg;
    logic [2:0][VAL_W-1:0]  i_a_reg;
    logic                   i_pe_reg;

    // A: abs w, plain products
    side_w_t                a_side_reg;
    logic [VAL_W-1:0]       a_absw_reg [3];
    logic signed [49:0]     a_pprod_reg [3];

    // B, C: plain sum and plain result
    side_w_t                b_side_reg;
    logic signed [51:0]     b_psum_reg;
    side_w_t                c_reg;
    logic [VAL_W:0]         plain_next;

    side_w_t                dl1_reg [LW-2];
    logic [QMAG_W-1:0]      wmag [3];

    // R: reciprocals of w
    side_w_t                r_side_reg;
    logic signed [VAL_W-1:0] r_val_reg [3];
    logic                   r_flag_reg;
    logic [VAL_W:0]         r_next [3];

    // M1..M5
    side_w_t                m1_side_reg;
    logic signed [49:0]     m1_br_reg [3];
    logic signed [63:0]     m1_ar_reg [3];
    logic                   m1_flag_reg;
    side_w_t                m2_side_reg;
    logic signed [51:0]     m2_dsum_reg;
    logic signed [VAL_W-1:0] m2_d_reg [3];
    logic                   m2_flag_reg;
    logic [VAL_W:0]         d_next [3];
    side_w_t                m3_side_reg;
    logic [DMAG_W-1:0]      m3_dabs_reg;
    logic                   m3_dneg_reg;
    logic                   m3_dzero_reg;
    logic signed [49:0]     m3_db_reg [3];
    logic                   m3_flag_reg;
    logic signed [51:0]     dsum_abs;
    side_w_t                m4_side_reg;
    logic signed [51:0]     m4_psum_reg;
    logic                   m4_dneg_reg;
    logic                   m4_dzero_reg;
    logic                   m4_flag_reg;
    side_d_t                m5_reg;
    logic [VAL_W:0]         p_next;

    side_d_t                dl2_reg [LD-2];
    logic [QMAG_W-1:0]      dmag;

    // final stages
    side_d_t                w_side_reg;
    logic signed [VAL_W-1:0] w_val_reg;
    logic [VAL_W:0]         wr_next;
    side_d_t                f1_side_reg;
    logic signed [63:0]     f1_prod_reg;
    logic [VAL_W-1:0]       f2_val_reg;
    logic                   f2_sat_reg;
    logic [VAL_W:0]         fin_next;

    // output buffer
    logic [VAL_W:0]         obuf_reg [2];
    logic                   wr_ptr_reg;
    logic                   rd_ptr_reg;
    logic [1:0]             ocnt_reg;
    logic                   push;
    logic                   pop;

    assign adv        = (ocnt_reg != 2'd2);
    assign frag.ready = adv;
    assign in_acc     = frag.valid & adv;
    assign cfg.ready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pe_reg <= 1'b1;
        else if (cfg.valid)
            pe_reg <= cfg.perspective_enable;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[NSTG-2:0], in_acc};
    end

    for (genvar g = 0; g < 3; g++)
    begin : g_wrecip
        pci_recip #(
            .K  (KW),
            .DW (VAL_W)
        ) u_wrecip (
            .clk (clk),
            .en  (adv),
            .d   (a_absw_reg[g]),
            .mag (wmag[g])
        );
    end

    pci_recip #(
        .K  (KD),
        .DW (DMAG_W)
    ) u_drecip (
        .clk (clk),
        .en  (adv),
        .d   (m3_dabs_reg),
        .mag (dmag)
    );

    always_comb
    begin
        plain_next = sat32(shr_rnd(b_psum_reg, WEIGHT_BITS));
        for (int i = 0; i < 3; i++)
        begin
            r_next[i] = recip_fix(wmag[i], dl1_reg[LW-3].wneg[i], dl1_reg[LW-3].wzero[i]);
            d_next[i] = sat32(shr_rnd(m1_ar_reg[i], FRAC_BITS));
        end
        dsum_abs = m2_dsum_reg[51] ? -m2_dsum_reg : m2_dsum_reg;
        p_next   = sat32(shr_rnd(m4_psum_reg, WEIGHT_BITS));
        wr_next  = recip_fix(dmag, dl2_reg[LD-3].dneg, dl2_reg[LD-3].dzero);
        fin_next = sat32(shr_rnd(f1_prod_reg, FRAC_BITS));
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            i_w_reg  <= {frag.clip_w_third, frag.clip_w_second, frag.clip_w_first};
            i_b_reg  <= {frag.bary_third, frag.bary_second, frag.bary_first};
            i_a_reg  <= {frag.attr_third, frag.attr_second, frag.attr_first};
            i_pe_reg <= pe_reg;

            a_side_reg.pe        <= i_pe_reg;
            a_side_reg.bary      <= i_b_reg;
            a_side_reg.attr      <= i_a_reg;
            a_side_reg.plain_res <= '0;
            a_side_reg.plain_sat <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                a_side_reg.wneg[i]  <= i_w_reg[i][VAL_W-1];
                a_side_reg.wzero[i] <= (i_w_reg[i] == '0);
                a_absw_reg[i]       <= i_w_reg[i][VAL_W-1] ? -i_w_reg[i] : i_w_reg[i];
                a_pprod_reg[i]      <= $signed(i_a_reg[i]) * $signed({1'b0, i_b_reg[i]});
            end

            b_side_reg <= a_side_reg;
            b_psum_reg <= a_pprod_reg[0] + a_pprod_reg[1] + a_pprod_reg[2];

            c_reg.pe        <= b_side_reg.pe;
            c_reg.wneg      <= b_side_reg.wneg;
            c_reg.wzero     <= b_side_reg.wzero;
            c_reg.bary      <= b_side_reg.bary;
            c_reg.attr      <= b_side_reg.attr;
            c_reg.plain_res <= plain_next[VAL_W-1:0];
            c_reg.plain_sat <= plain_next[VAL_W];

            dl1_reg[0] <= c_reg;
            for (int k = 1; k < LW - 2; k++)
                dl1_reg[k] <= dl1_reg[k-1];

            r_side_reg <= dl1_reg[LW-3];
            r_flag_reg <= r_next[0][VAL_W] | r_next[1][VAL_W] | r_next[2][VAL_W];
            for (int i = 0; i < 3; i++)
                r_val_reg[i] <= r_next[i][VAL_W-1:0];

            m1_side_reg <= r_side_reg;
            m1_flag_reg <= r_flag_reg;
            for (int i = 0; i < 3; i++)
            begin
                m1_br_reg[i] <= r_val_reg[i] * $signed({1'b0, r_side_reg.bary[i]});
                m1_ar_reg[i] <= $signed(r_side_reg.attr[i]) * r_val_reg[i];
            end

            m2_side_reg <= m1_side_reg;
            m2_dsum_reg <= m1_br_reg[0] + m1_br_reg[1] + m1_br_reg[2];
            m2_flag_reg <= m1_flag_reg | d_next[0][VAL_W] | d_next[1][VAL_W]
                           | d_next[2][VAL_W];
            for (int i = 0; i < 3; i++)
                m2_d_reg[i] <= d_next[i][VAL_W-1:0];

            m3_side_reg  <= m2_side_reg;
            m3_dabs_reg  <= dsum_abs[DMAG_W-1:0];
            m3_dneg_reg  <= m2_dsum_reg[51];
            m3_dzero_reg <= (m2_dsum_reg == '0);
            m3_flag_reg  <= m2_flag_reg;
            for (int i = 0; i < 3; i++)
                m3_db_reg[i] <= m2_d_reg[i] * $signed({1'b0, m2_side_reg.bary[i]});

            m4_side_reg  <= m3_side_reg;
            m4_psum_reg  <= m3_db_reg[0] + m3_db_reg[1] + m3_db_reg[2];
            m4_dneg_reg  <= m3_dneg_reg;
            m4_dzero_reg <= m3_dzero_reg;
            m4_flag_reg  <= m3_flag_reg;

            m5_reg.pe        <= m4_side_reg.pe;
            m5_reg.plain_res <= m4_side_reg.plain_res;
            m5_reg.plain_sat <= m4_side_reg.plain_sat;
            m5_reg.dneg      <= m4_dneg_reg;
            m5_reg.dzero     <= m4_dzero_reg;
            m5_reg.pval      <= p_next[VAL_W-1:0];
            m5_reg.flag      <= m4_flag_reg | p_next[VAL_W];

            dl2_reg[0] <= m5_reg;
            for (int k = 1; k < LD - 2; k++)
                dl2_reg[k] <= dl2_reg[k-1];

            w_side_reg.pe        <= dl2_reg[LD-3].pe;
            w_side_reg.plain_res <= dl2_reg[LD-3].plain_res;
            w_side_reg.plain_sat <= dl2_reg[LD-3].plain_sat;
            w_side_reg.dneg      <= dl2_reg[LD-3].dneg;
            w_side_reg.dzero     <= dl2_reg[LD-3].dzero;
            w_side_reg.pval      <= dl2_reg[LD-3].pval;
            w_side_reg.flag      <= dl2_reg[LD-3].flag | wr_next[VAL_W];
            w_val_reg            <= wr_next[VAL_W-1:0];

            f1_side_reg <= w_side_reg;
            f1_prod_reg <= $signed(w_side_reg.pval) * w_val_reg;

            f2_val_reg <= f1_side_reg.pe ? fin_next[VAL_W-1:0] : f1_side_reg.plain_res;
            f2_sat_reg <= f1_side_reg.pe ? (f1_side_reg.flag | fin_next[VAL_W])
                                         : f1_side_reg.plain_sat;
        end
    end

    // output buffer: two beats, so the pipe keeps moving while the sink stalls until it fills
    assign push = adv & vld_reg[NSTG-1];
    assign pop  = result.valid & result.ready;

    always_ff @(posedge clk)
    begin
        if (push)
            obuf_reg[wr_ptr_reg] <= {f2_sat_reg, f2_val_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            ocnt_reg   <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            if (push && !pop)
                ocnt_reg <= ocnt_reg + 2'd1;
            else if (pop && !push)
                ocnt_reg <= ocnt_reg - 2'd1;
        end
    end

    assign result.valid        = (ocnt_reg != 2'd0);
    assign result.interp_value = obuf_reg[rd_ptr_reg][VAL_W-1:0];
    assign result.saturated    = obuf_reg[rd_ptr_reg][VAL_W];

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        ocnt_reg != 2'd3)
        else $error("output buffer count out of range");

    a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        ocnt_reg == 2'd2 |-> !frag.ready && !push)
        else $error("pipe advanced with full output buffer");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        frag.valid && frag.ready |=> vld_reg[0])
        else $error("accepted beat missing from pipe");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        ocnt_reg == 2'd0 && !vld_reg[NSTG-1] |=> !result.valid)
        else $error("result beat without source");
endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// Testbench for perspective_correct_interpolator_top: random and directed fragment beats,
// a bit-exact fixed-point predictor, and in-order checking of results.
// Depends on pci_pkg, pci_if and the RTL of the interpolator.
module testbench;
    import pci_pkg::*;

    typedef struct packed {
        logic signed [VAL_W-1:0] w0, w1, w2;
        logic [BARY_W-1:0]       b0, b1, b2;
        logic signed [VAL_W-1:0] a0, a1, a2;
    } frag_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic                    sat;
    } interp_t;

    localparam int FB        = FRAC_BITS_DEF;
    localparam int LATENCY   = 4 * FB + 31;
    localparam longint LIMIT = 400000;
    localparam longint I32MAX = 64'sd2147483647;
    localparam longint I32MIN = -64'sd2147483648;

    logic clk;
    logic rst_n;
    pci_cfg_if    cfg_ch();
    pci_frag_if   frag_ch();
    pci_result_if res_ch();

    perspective_correct_interpolator_top u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_ch.sink),
        .frag   (frag_ch.sink),
        .result (res_ch.source)
    );

    frag_t   frag_queue[$];
    interp_t expected_q[$];
    logic    persp_mode;
    int      errors;
    int      checked;
    int      sat_seen;
    longint  cycles;
    bit      calm;        // no idling in the closing stretch
    bit      hold_frags;  // sender paused by the stimulus block
    int      src_gap;
    int      snk_gap;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic longint clamp32(input longint x, inout bit flag);
        if (x > I32MAX) begin
            flag = 1'b1;
            return I32MAX;
        end
        if (x < I32MIN) begin
            flag = 1'b1;
            return I32MIN;
        end
        return x;
    endfunction

    // round half up, arithmetic shift
    function automatic longint round_shift(input longint x, input int s);
        longint t;
        t = x + (64'sd1 <<< (s - 1));
        return t >>> s;
    endfunction

    // round(2^k / d), d > 0, capped at 2^32
    function automatic longint recip_magnitude(input int k, input longint unsigned d);
        longint unsigned q, r;
        logic [64:0] num;
        if (k >= 32 && (d >> (k - 32)) == 0)
            return 64'sd1 <<< 32;
        num = 65'd1 << k;
        q = 64'(num / d);
        r = 64'(num % d);
        if (r >= d - r)
            q++;
        return longint'(q);
    endfunction

    function automatic longint recip_q(input int k, input longint d, inout bit flag);
        if (d == 0) begin
            flag = 1'b1;
            return I32MAX;
        end
        if (d > 0)
            return clamp32(recip_magnitude(k, d), flag);
        return clamp32(-recip_magnitude(k, -d), flag);
    endfunction

    function automatic interp_t interpolate(input frag_t f, input logic persp);
        longint  w[3], b[3], a[3], r[3];
        longint  dsum, psum, wr, p, res, acc, d;
        bit      flag;
        interp_t o;
        w = '{f.w0, f.w1, f.w2};
        b = '{longint'(f.b0), longint'(f.b1), longint'(f.b2)};
        a = '{f.a0, f.a1, f.a2};
        flag = 1'b0;
        if (!persp) begin
            acc = 0;
            for (int i = 0; i < 3; i++)
                acc += a[i] * b[i];
            res = clamp32(round_shift(acc, WEIGHT_BITS), flag);
        end
        else begin
            dsum = 0;
            psum = 0;
            for (int i = 0; i < 3; i++) begin
                r[i] = recip_q(2 * FB, w[i], flag);
                dsum += b[i] * r[i];
            end
            wr = recip_q(2 * FB + WEIGHT_BITS, dsum, flag);
            for (int i = 0; i < 3; i++) begin
                d = clamp32(round_shift(a[i] * r[i], FB), flag);
                psum += d * b[i];
            end
            p = clamp32(round_shift(psum, WEIGHT_BITS), flag);
            res = clamp32(round_shift(p * wr, FB), flag);
        end
        o.value = res[31:0];
        o.sat = flag;
        return o;
    endfunction

    function automatic logic [31:0] rand_q();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return $urandom_range(0, 32'h0003_0000) - 32'h0001_8000;
            2: return {{8{1'b0}}, 24'($urandom)} | 32'h0000_1000;
            3: return -{{12{1'b0}}, 20'($urandom)};
            4: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return $urandom_range(32'h0000_8000, 32'h0010_0000);
        endcase
    endfunction

    function automatic frag_t rand_frag();
        frag_t f;
        int    s0, s1;
        f.w0 = rand_q();
        f.w1 = rand_q();
        f.w2 = rand_q();
        if ($urandom_range(0, 29) == 0)
            f.w1 = '0;
        f.a0 = rand_q();
        f.a1 = rand_q();
        f.a2 = rand_q();
        if ($urandom_range(0, 4) != 0) begin
            // weights summing to one
            s0 = $urandom_range(0, 65536);
            s1 = $urandom_range(0, 65536 - s0);
            f.b0 = BARY_W'(s0);
            f.b1 = BARY_W'(s1);
            f.b2 = BARY_W'(65536 - s0 - s1);
        end
        else begin
            f.b0 = BARY_W'($urandom);
            f.b1 = BARY_W'($urandom);
            f.b2 = BARY_W'($urandom);
        end
        return f;
    endfunction

    // sender
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            frag_ch.valid <= 1'b0;
            frag_ch.clip_w_first <= '0;
            frag_ch.clip_w_second <= '0;
            frag_ch.clip_w_third <= '0;
            frag_ch.bary_first <= '0;
            frag_ch.bary_second <= '0;
            frag_ch.bary_third <= '0;
            frag_ch.attr_first <= '0;
            frag_ch.attr_second <= '0;
            frag_ch.attr_third <= '0;
            src_gap <= 0;
        end
        else if (!frag_ch.valid || frag_ch.ready) begin
            // the beat on the wires is the queue head until it is accepted
            if (frag_ch.valid && frag_ch.ready)
                expected_q.push_back(interpolate(frag_queue.pop_front(), persp_mode));
            if (src_gap > 0) begin
                src_gap <= src_gap - 1;
                frag_ch.valid <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 9) == 0) begin
                src_gap <= $urandom_range(0, 2);
                frag_ch.valid <= 1'b0;
            end
            else if (!hold_frags && frag_queue.size() > 0) begin
                frag_t f;
                f = frag_queue[0];
                frag_ch.valid <= 1'b1;
                frag_ch.clip_w_first <= f.w0;
                frag_ch.clip_w_second <= f.w1;
                frag_ch.clip_w_third <= f.w2;
                frag_ch.bary_first <= f.b0;
                frag_ch.bary_second <= f.b1;
                frag_ch.bary_third <= f.b2;
                frag_ch.attr_first <= f.a0;
                frag_ch.attr_second <= f.a1;
                frag_ch.attr_third <= f.a2;
            end
            else
                frag_ch.valid <= 1'b0;
        end
    end

    // receiver and checker
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            res_ch.ready <= 1'b0;
            snk_gap <= 0;
        end
        else begin
            if (res_ch.valid && res_ch.ready) begin
                if (expected_q.size() == 0) begin
                    $error("result beat with nothing expected: value %0d", res_ch.interp_value);
                    errors++;
                end
                else begin
                    interp_t e;
                    e = expected_q.pop_front();
                    checked++;
                    if (e.sat)
                        sat_seen++;
                    if (res_ch.interp_value !== e.value) begin
                        $error("interp_value expected %0d actual %0d", e.value,
                               res_ch.interp_value);
                        errors++;
                    end
                    if (res_ch.saturated !== e.sat) begin
                        $error("saturated expected %0b actual %0b", e.sat, res_ch.saturated);
                        errors++;
                    end
                end
            end
            if (snk_gap > 0) begin
                snk_gap <= snk_gap - 1;
                res_ch.ready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 7) == 0) begin
                snk_gap <= $urandom_range(0, 2);
                res_ch.ready <= 1'b0;
            end
            else
                res_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("** perspective_correct_interpolator_top: FAILED **");
            $finish;
        end
    end

    task automatic wait_drained();
        while (frag_queue.size() != 0 || frag_ch.valid || expected_q.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 5) @(posedge clk);
    endtask

    task automatic write_mode(input logic mode);
        cfg_ch.perspective_enable <= mode;
        cfg_ch.valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        persp_mode = mode;
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic push_frag(input logic [31:0] w0, w1, w2, input int b0, b1, b2,
                             input logic [31:0] a0, a1, a2);
        frag_t f;
        f = '{w0, w1, w2, b0[16:0], b1[16:0], b2[16:0], a0, a1, a2};
        frag_queue.push_back(f);
    endtask

    task automatic directed_set();
        push_frag(32'h1_0000, 32'h1_0000, 32'h1_0000, 65536, 0, 0,
                  32'h7FFF_FFFF, 32'h8000_0000, 0);
        push_frag(32'h2_0000, 32'h4_0000, 32'h8_0000, 21845, 21845, 21846,
                  32'h1_0000, 32'h2_0000, 32'h3_0000);
        push_frag(0, 32'h1_0000, 32'h1_0000, 32768, 16384, 16384, 5, 6, 7);  // zero w
        push_frag(0, 0, 0, 65536, 0, 0, 32'h1_0000, 0, 0);
        push_frag(32'h1_0000, 32'h1_0000, 32'h1_0000, 0, 0, 0, 1, 2, 3);  // zero sum
        push_frag(32'h1_0000, 32'hFFFF_0000, 32'h1_0000, 32768, 32768, 0, 1, 2, 3);
        push_frag(32'h7FFF_FFFF, 32'h8000_0000, 1, 131071, 131071, 131071,
                  32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
        push_frag(32'hFFFF_FFFF, 1, 32'h8000_0000, 65536, 65536, 65536,
                  32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        push_frag(32'h0000_0100, 32'h0100_0000, 32'hFFFF_FF00, 1, 2, 65533,
                  32'hFFFF_FFFF, 0, 1);
        push_frag(32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F, 65535, 1, 0,
                  32'hAAAA_AAAA, 32'h5555_5555, 32'hF0F0_F0F0);
    endtask

    initial begin
        logic modes[6];
        errors = 0;
        checked = 0;
        sat_seen = 0;
        cycles = 0;
        calm = 0;
        hold_frags = 0;
        persp_mode = 1'b1;
        rst_n = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.perspective_enable = 1'b1;
        res_ch.ready = 1'b0;
        frag_ch.valid = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset default: perspective on
        directed_set();
        wait_drained();
        modes = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
        foreach (modes[m]) begin
            write_mode(modes[m]);
            if (m == 0)
                directed_set();
            if (m == 5)
                calm = 1;
            for (int i = 0; i < 230; i++) begin
                frag_queue.push_back(rand_frag());
                if (i == 100 && m == 3) begin
                    // sender holds until every beat in flight has come back
                    hold_frags = 1;
                    while (frag_ch.valid || expected_q.size() != 0)
                        @(posedge clk);
                    hold_frags = 0;
                end
            end
            wait_drained();
        end

        $display("checked %0d result beats over %0d mode settings, %0d with clamp flag",
                 checked, 7, sat_seen);
        if (errors == 0)
            $display("** perspective_correct_interpolator_top: PASSED **");
        else
            $display("** perspective_correct_interpolator_top: FAILED **");
        $finish;
    end
endmodule
